// ===== sv/aqpc_pkg.sv =====
`timescale 1ns / 1ps
package aqpc_pkg;

    // block constants
    localparam int MAX_SLOTS  = 16;
    localparam int ASPECT_Q16 = 131072;
    localparam int FRAC_BITS  = 16;

    // fixed field widths
    localparam int SLOT_W    = 4;
    localparam int COLOUR_W  = 3;
    localparam int PIX_W     = 12;
    localparam int SCREEN_W  = 13;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 31;
    localparam int CFG_IDX_W = 3;

    // derived widths
    localparam int SLOT_IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W      = (SLOT_IDX_W > 3) ? SLOT_IDX_W : 3;
    localparam int ASPECT_W   = $clog2(ASPECT_Q16 + 1) + 1;
    localparam int DXY_W      = SCREEN_W;
    localparam int DY_PROD_W  = DXY_W + ASPECT_W;
    localparam int SUM_BASE_W = (DXY_W + FRAC_BITS > DY_PROD_W) ?
                                (DXY_W + FRAC_BITS) : DY_PROD_W;
    localparam int SUM_W      = ((SUM_BASE_W > DATA_W) ? SUM_BASE_W : DATA_W) + 1;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int W_W        = PROD_W - FRAC_BITS + 1;
    localparam int EDGE_W     = DATA_W + 1;
    localparam int MUL_STEPS  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_A       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_B       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_C       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_D       = 3'd7;

    // input op codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // multiplier step select: which product is formed
    localparam logic [1:0] MSEL_VX_A = 2'd0;
    localparam logic [1:0] MSEL_VY_B = 2'd1;
    localparam logic [1:0] MSEL_VX_C = 2'd2;
    localparam logic [1:0] MSEL_VY_D = 2'd3;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_XFORM = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } aqpc_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic                  load_pix;
        logic                  write_slot;
        logic                  xform;
        logic                  mul_issue;
        logic [1:0]            mul_sel;
        logic                  mul_acc;
        logic [1:0]            acc_sel;
        logic                  scan_step;
        logic [SLOT_IDX_W-1:0] scan_idx;
    } aqpc_cmd_t;

    // clamp a wide sum into the signed 32 bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[SUM_W-1:DATA_W-1];
        all_zero = ~|v[SUM_W-1:DATA_W-1];
        if (all_one || all_zero)
            return v[DATA_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

// ===== sv/aqpc_ctrl.sv =====
`timescale 1ns / 1ps
module aqpc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                op,
    output logic                busy,
    output logic                out_valid,
    output aqpc_pkg::aqpc_cmd_t cmd
);
    import aqpc_pkg::*;

    aqpc_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    // handshake
    assign busy      = !(state_reg == ST_IDLE || state_reg == ST_DONE);
    assign out_valid = (state_reg == ST_DONE);
    assign accept    = start && !busy;

    // next state and step counter
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if (accept && op == OP_PIXEL)
                    state_next = ST_XFORM;
                else
                    state_next = ST_IDLE;
                cnt_next = '0;
            end
            ST_XFORM:
            begin
                state_next = ST_MUL;
                cnt_next   = '0;
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_STEPS))
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(MAX_SLOTS - 1))
                begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // command decode
    always_comb
    begin
        cmd            = '0;
        cmd.load_pix   = accept && (op == OP_PIXEL);
        cmd.write_slot = accept && (op == OP_WRITE);
        cmd.xform      = (state_reg == ST_XFORM);
        cmd.mul_issue  = (state_reg == ST_MUL) && (cnt_reg < CNT_W'(MUL_STEPS));
        cmd.mul_sel    = cnt_reg[1:0];
        cmd.mul_acc    = (state_reg == ST_MUL) && (cnt_reg != '0);
        cmd.acc_sel    = cnt_reg[1:0] - 2'd1;
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.scan_idx   = cnt_reg[SLOT_IDX_W-1:0];
    end

`ifndef SYNTHESIS
    // a result strobe only follows the last scan step
    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(state_reg == ST_SCAN))
        else $error("result strobe without a finished scan");

    // a slot write leaves the block free
    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_WRITE) |=> !busy)
        else $error("slot write made the block busy");

    // a pixel beat always starts the transform
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_PIXEL) |=> (state_reg == ST_XFORM))
        else $error("pixel beat did not start the transform");

    // multiply step count stays in range
    a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (cnt_reg <= CNT_W'(MUL_STEPS)))
        else $error("multiply step counter out of range");
`endif

endmodule

// ===== sv/aqpc_dp.sv =====
`timescale 1ns / 1ps
module aqpc_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  aqpc_pkg::aqpc_cmd_t                   cmd,
    input  logic                                  cfg_we,
    input  logic [aqpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [aqpc_pkg::DATA_W-1:0]           cfg_data,
    input  logic [aqpc_pkg::SLOT_W-1:0]           slot,
    input  logic                                  slot_enable,
    input  logic signed [aqpc_pkg::DATA_W-1:0]    rect_left,
    input  logic signed [aqpc_pkg::DATA_W-1:0]    rect_bottom,
    input  logic [aqpc_pkg::SIZE_W-1:0]           rect_width,
    input  logic [aqpc_pkg::SIZE_W-1:0]           rect_height,
    input  logic [aqpc_pkg::COLOUR_W-1:0]         rect_colour,
    input  logic [aqpc_pkg::PIX_W-1:0]            pix_x,
    input  logic [aqpc_pkg::PIX_W-1:0]            pix_y,
    output logic [aqpc_pkg::COLOUR_W-1:0]         pixel_colour,
    output logic                                  covered
);
    import aqpc_pkg::*;

    localparam logic signed [ASPECT_W-1:0] ASPECT_S = ASPECT_W'(ASPECT_Q16);

    // configuration registers
    logic [SCREEN_W-1:0]      cols_reg, rows_reg;
    logic signed [DATA_W-1:0] off_x_reg, off_y_reg;
    logic signed [DATA_W-1:0] mat_a_reg, mat_b_reg, mat_c_reg, mat_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= SCREEN_W'(80);
            rows_reg  <= SCREEN_W'(24);
            off_x_reg <= '0;
            off_y_reg <= '0;
            mat_a_reg <= DATA_W'(1) <<< FRAC_BITS;
            mat_b_reg <= '0;
            mat_c_reg <= '0;
            mat_d_reg <= DATA_W'(1) <<< FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_COLS: cols_reg  <= cfg_data[SCREEN_W-1:0];
                CFG_SCREEN_ROWS: rows_reg  <= cfg_data[SCREEN_W-1:0];
                CFG_OFFSET_X:    off_x_reg <= cfg_data;
                CFG_OFFSET_Y:    off_y_reg <= cfg_data;
                CFG_MAT_A:       mat_a_reg <= cfg_data;
                CFG_MAT_B:       mat_b_reg <= cfg_data;
                CFG_MAT_C:       mat_c_reg <= cfg_data;
                CFG_MAT_D:       mat_d_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // slot table: enable bits in flops, edges stored as left/right/bottom/top
    logic [MAX_SLOTS-1:0]     valid_reg;
    logic signed [DATA_W-1:0] left_mem   [MAX_SLOTS];
    logic signed [EDGE_W-1:0] right_mem  [MAX_SLOTS];
    logic signed [DATA_W-1:0] bottom_mem [MAX_SLOTS];
    logic signed [EDGE_W-1:0] top_mem    [MAX_SLOTS];
    logic [COLOUR_W-1:0]      colour_mem [MAX_SLOTS];
    logic                     slot_in_range;
    logic [SLOT_IDX_W-1:0]    wr_idx;

    assign slot_in_range = (int'(slot) < MAX_SLOTS);
    assign wr_idx        = SLOT_IDX_W'(slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.write_slot && slot_in_range)
            valid_reg[wr_idx] <= slot_enable;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_slot && slot_in_range)
        begin
            left_mem[wr_idx]   <= rect_left;
            right_mem[wr_idx]  <= EDGE_W'(rect_left) + $signed({2'b00, rect_width});
            bottom_mem[wr_idx] <= rect_bottom;
            top_mem[wr_idx]    <= EDGE_W'(rect_bottom) + $signed({2'b00, rect_height});
            colour_mem[wr_idx] <= rect_colour;
        end
    end

    // pixel latch
    logic [PIX_W-1:0] pix_x_reg, pix_y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            pix_x_reg <= pix_x;
            pix_y_reg <= pix_y;
        end
    end

    // centring, aspect and view offset with saturation
    logic signed [DXY_W-1:0]     dx, dy;
    logic signed [DY_PROD_W-1:0] dy_scaled;
    logic signed [SUM_W-1:0]     vx_sum, vy_sum;
    logic signed [DATA_W-1:0]    vx_reg, vy_reg;

    assign dx        = $signed({1'b0, pix_x_reg}) - $signed({1'b0, cols_reg[SCREEN_W-1:1]});
    assign dy        = $signed({1'b0, pix_y_reg}) - $signed({1'b0, rows_reg[SCREEN_W-1:1]});
    assign dy_scaled = DY_PROD_W'(dy) * DY_PROD_W'(ASPECT_S);
    assign vx_sum    = (SUM_W'(dx) <<< FRAC_BITS) + SUM_W'(off_x_reg);
    assign vy_sum    = SUM_W'(dy_scaled) + SUM_W'(off_y_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.xform)
        begin
            vx_reg <= sat32(vx_sum);
            vy_reg <= sat32(vy_sum);
        end
    end

    // shared multiplier, one product per step, registered
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_res, prod_reg;
    logic signed [W_W-1:0]    prod_term;
    logic signed [W_W-1:0]    wx_reg, wy_reg;

    always_comb
    begin
        mul_a = vx_reg;
        mul_b = mat_a_reg;
        case (cmd.mul_sel)
            MSEL_VX_A: begin mul_a = vx_reg; mul_b = mat_a_reg; end
            MSEL_VY_B: begin mul_a = vy_reg; mul_b = mat_b_reg; end
            MSEL_VX_C: begin mul_a = vx_reg; mul_b = mat_c_reg; end
            MSEL_VY_D: begin mul_a = vy_reg; mul_b = mat_d_reg; end
            default:   begin mul_a = vx_reg; mul_b = mat_a_reg; end
        endcase
    end

    assign mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
            prod_reg <= mul_res;
    end

    // floor shift of the product, then accumulate into wx and wy
    assign prod_term = $signed({prod_reg[PROD_W-1], prod_reg[PROD_W-1:FRAC_BITS]});

    always_ff @(posedge clk)
    begin
        if (cmd.mul_acc)
        begin
            case (cmd.acc_sel)
                MSEL_VX_A: wx_reg <= prod_term;
                MSEL_VY_B: wx_reg <= wx_reg + prod_term;
                MSEL_VX_C: wy_reg <= prod_term;
                MSEL_VY_D: wy_reg <= wy_reg + prod_term;
                default:   ;
            endcase
        end
    end

    // slot scan, lowest first so the highest covering slot wins
    logic                  hit_now;
    logic [SLOT_IDX_W-1:0] si;

    assign si      = cmd.scan_idx;
    assign hit_now = valid_reg[si]
                  && (wx_reg >= W_W'(left_mem[si]))   && (wx_reg < W_W'(right_mem[si]))
                  && (wy_reg >= W_W'(bottom_mem[si])) && (wy_reg < W_W'(top_mem[si]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_colour <= '0;
            covered      <= 1'b0;
        end
        else if (cmd.xform)
        begin
            pixel_colour <= '0;
            covered      <= 1'b0;
        end
        else if (cmd.scan_step && hit_now)
        begin
            pixel_colour <= colour_mem[si];
            covered      <= 1'b1;
        end
    end

endmodule

// ===== sv/affine_quad_pixel_compositor_top.sv =====
`timescale 1ns / 1ps
// affine quad pixel compositor
// command channel: an item is taken at a clock edge with start high and busy low.
//   op selects a slot write (slot, slot_enable, rect_*) or a pixel query (pix_x, pix_y).
// a slot write is done in the accepting beat; busy stays low and no result follows.
// a pixel query runs a transform step, then steps on the shared 32x32 multiplier
//   (four products, floor shift and add), then a scan that visits all 16 slots in turn.
// its result is shown with out_valid high for exactly one cycle, and is taken at
//   the edge that ends that cycle; pixel_colour and covered hold until the next
//   query reaches its transform step.
// a new item may be started in the cycle that out_valid is high; no new item is
//   taken while a query is in its transform, multiply or slot scan steps; slot
//   writes can follow each other every cycle.
// the receiver cannot stall: the result beat is taken in the cycle it is shown.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high; write only while no query is in flight.
// reset (rst_n low, asynchronous) disables every slot and loads the default
//   screen size 80x24, zero offset and the identity matrix.
module affine_quad_pixel_compositor_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  op,
    input  logic [aqpc_pkg::SLOT_W-1:0]           slot,
    input  logic                                  slot_enable,
    input  logic signed [aqpc_pkg::DATA_W-1:0]    rect_left,
    input  logic signed [aqpc_pkg::DATA_W-1:0]    rect_bottom,
    input  logic [aqpc_pkg::SIZE_W-1:0]           rect_width,
    input  logic [aqpc_pkg::SIZE_W-1:0]           rect_height,
    input  logic [aqpc_pkg::COLOUR_W-1:0]         rect_colour,
    input  logic [aqpc_pkg::PIX_W-1:0]            pix_x,
    input  logic [aqpc_pkg::PIX_W-1:0]            pix_y,
    output logic                                  out_valid,
    output logic [aqpc_pkg::COLOUR_W-1:0]         pixel_colour,
    output logic                                  covered,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [aqpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [aqpc_pkg::DATA_W-1:0]           cfg_data
);
    import aqpc_pkg::*;

    aqpc_cmd_t cmd;

    // config channel always ready
    assign cfg_ready = 1'b1;

    // controller
    aqpc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .busy      (busy),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // datapath
    aqpc_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .slot         (slot),
        .slot_enable  (slot_enable),
        .rect_left    (rect_left),
        .rect_bottom  (rect_bottom),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .rect_colour  (rect_colour),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .pixel_colour (pixel_colour),
        .covered      (covered)
    );

endmodule
